// ----- design/bfa_pkg.sv -----
// bfa_pkg: shared types and constants for the bitmap frame allocator.
// Holds the word structs, command codes, sequencer states and field widths.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int CNT_W   = 13;  // frame count / used count width
	localparam int ADDR_W  = 24;  // byte address width
	localparam int BYTES_W = 25;  // region length width
	localparam int CMD_W   = 3;
	localparam int SPAN_W  = 26;  // holds addr + region_bytes + frame size - 1

	localparam int DEF_NUM_FRAMES  = 4096;
	localparam int DEF_FRAME_BYTES = 4096;
	localparam int DEF_WORD_BITS   = 64;

	localparam int CNT_MAX      = 8191;
	localparam int RESET_FRAMES = 4096;

	localparam logic [CMD_W-1:0] CMD_ALLOC_ONE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC_RUN = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MARK_AVL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MARK_RSV  = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [ADDR_W-1:0]  addr;
		logic [BYTES_W-1:0] region_bytes;
		logic [CNT_W-1:0]   run_frames;
	} in_word_t;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] frame_addr;
		logic [CNT_W-1:0]  used_frames;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_BIT,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_ONE,
		MODE_RUN,
		MODE_MARK
	} mode_t;

endpackage

// ----- design/bitmap_frame_allocator.sv -----
// channel  dir   handshake              word contents
// in       sink  in_valid / in_stall    bfa_pkg::in_word_t  (cmd, addr, region_bytes, run_frames)
// out      src   out_valid / out_stall  bfa_pkg::out_word_t (ok, frame_addr, used_frames)
// cfg      sink  cfg_we                 cfg_data = frame_count
//
// After reset the bitmap RAM is filled with ones, one word per cycle, all WORDS words
// (64 by default) with in_stall high. Commands walk the RAM with one frame cursor: each
// word is read (READ, LOAD), its frames are examined bit by bit (BIT) and it is written
// back (WRITE) when a frame in it is allocated or marked, between accept and result.
// Fully used words (and fully free words that cannot finish a run) are skipped.
// A finished word waits in the output register; in_stall is low only while idle.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bitmap_frame_allocator #(
	parameter int NUM_FRAMES  = bfa_pkg::DEF_NUM_FRAMES,
	parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES,
	parameter int WORD_BITS   = bfa_pkg::DEF_WORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  bfa_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output bfa_pkg::out_word_t           out_data,
	input  logic                         cfg_we,
	input  logic [bfa_pkg::CNT_W-1:0]    cfg_data
);
	import bfa_pkg::*;

	localparam int FB_SH  = $clog2(FRAME_BYTES);
	localparam int WB_SH  = $clog2(WORD_BITS);
	localparam int WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int NF_CAP = (NUM_FRAMES > CNT_MAX) ? CNT_MAX : NUM_FRAMES;

	localparam logic [CNT_W-1:0] NF_CAP_V  = CNT_W'(NF_CAP);
	localparam logic [CNT_W-1:0] RESET_FC  = (RESET_FRAMES > NF_CAP) ? NF_CAP_V
		: CNT_W'(RESET_FRAMES);
	localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);

	function automatic logic [ADDR_W-1:0] frame_to_addr(input logic [CNT_W-1:0] f);
		logic [CNT_W+FB_SH-1:0] w;
		w = (CNT_W+FB_SH)'(f) << FB_SH;
		return ADDR_W'(w);
	endfunction

	// bitmap RAM
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	logic [CNT_W-1:0]     fc_q, fc_d, used_q, used_d;
	logic [CNT_W-1:0]     cur_q, cur_d, stop_q, stop_d, len_q, len_d, run_q, run_d;
	logic                 reserve_q, reserve_d, fin_q, fin_d;
	logic                 res_ok_q, res_ok_d;
	logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic [AW-1:0]        wa_q, wa_d, clr_q, clr_d;
	logic                 out_valid_q;
	out_word_t            out_data_q;

	// cursor helpers
	logic [CNT_W+AW-1:0]  cur_wide;
	logic [AW-1:0]        cur_word;
	logic [WB_SH-1:0]     bit_idx;
	logic                 cur_bit;
	logic [CNT_W:0]       nxt, word_nxt;
	logic                 nxt_end, nxt_wrap, word_in, word_end;
	logic [CNT_W-1:0]     len_n;
	logic                 run_hit, ld_all1, ld_all0, skip;
	logic                 accept, out_free;
	logic [CNT_W-1:0]     cfg_fc;

	// command decode
	logic [SPAN_W-1:0]    addr_x, first_f, end_f, fr_f, fc_x, stopc_x;
	logic                 dec_launch, dec_ok, dec_reserve;
	mode_t                dec_mode;
	logic [CNT_W-1:0]     dec_cur, dec_stop;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_fc   = (cfg_data < NF_CAP_V) ? cfg_data : NF_CAP_V;

	assign cur_wide = (CNT_W+AW)'(cur_q) >> WB_SH;
	assign cur_word = cur_wide[AW-1:0];
	assign bit_idx  = cur_q[WB_SH-1:0];
	assign cur_bit  = word_q[bit_idx];
	assign nxt      = (CNT_W+1)'(cur_q) + (CNT_W+1)'(1);
	assign nxt_end  = nxt >= (CNT_W+1)'(stop_q);
	assign nxt_wrap = (bit_idx == {WB_SH{1'b1}});
	assign word_nxt = (CNT_W+1)'(cur_q) + (CNT_W+1)'(WORD_BITS);
	assign word_in  = word_nxt <= (CNT_W+1)'(stop_q);
	assign word_end = word_nxt >= (CNT_W+1)'(stop_q);
	assign len_n    = cur_bit ? '0 : len_q + CNT_W'(1);
	assign run_hit  = (mode_q == MODE_RUN) && (len_n == run_q);
	assign ld_all1  = (rd_data_q == {WORD_BITS{1'b1}});
	assign ld_all0  = (rd_data_q == {WORD_BITS{1'b0}});

	// whole-word skip while scanning: used word, or free word that cannot finish the run
	always_comb begin
		skip = 1'b0;
		if (word_in) begin
			case (mode_q)
				MODE_ONE: skip = ld_all1;
				MODE_RUN: skip = ld_all1 || (ld_all0 &&
					((CNT_W+1)'(len_q) + (CNT_W+1)'(WORD_BITS) < (CNT_W+1)'(run_q)));
				default:  skip = 1'b0;
			endcase
		end
	end

	// region [ceil(addr/FB), ceil((addr+bytes)/FB)) clipped to the frame count
	always_comb begin
		addr_x  = SPAN_W'(in_data.addr);
		fc_x    = SPAN_W'(fc_q);
		first_f = (addr_x + SPAN_W'(FRAME_BYTES - 1)) >> FB_SH;
		end_f   = (addr_x + SPAN_W'(in_data.region_bytes) + SPAN_W'(FRAME_BYTES - 1)) >> FB_SH;
		fr_f    = addr_x >> FB_SH;
		stopc_x = (end_f < fc_x) ? end_f : fc_x;

		dec_launch  = 1'b0;
		dec_ok      = 1'b0;
		dec_reserve = 1'b0;
		dec_mode    = MODE_MARK;
		dec_cur     = '0;
		dec_stop    = fc_q;
		unique case (in_data.cmd) inside
			CMD_ALLOC_ONE: begin
				dec_mode   = MODE_ONE;
				dec_launch = used_q < fc_q;
			end
			CMD_ALLOC_RUN: begin
				dec_mode   = MODE_RUN;
				dec_launch = (in_data.run_frames != '0) && (in_data.run_frames <= fc_q)
					&& ((CNT_W+1)'(used_q) + (CNT_W+1)'(in_data.run_frames)
					<= (CNT_W+1)'(fc_q));
			end
			CMD_FREE: begin
				dec_ok     = 1'b1;
				dec_launch = fr_f < fc_x;
				dec_cur    = CNT_W'(fr_f);
				dec_stop   = CNT_W'(fr_f) + CNT_W'(1);
			end
			CMD_MARK_AVL, CMD_MARK_RSV: begin
				dec_ok      = 1'b1;
				dec_reserve = (in_data.cmd == CMD_MARK_RSV);
				dec_launch  = first_f < stopc_x;
				dec_cur     = CNT_W'(first_f);
				dec_stop    = CNT_W'(stopc_x);
			end
			default: dec_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == LAST_WORD) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = dec_launch ? ST_READ : ST_DONE;
			ST_READ:  state_d = ST_LOAD;
			ST_LOAD: begin
				if (mode_q != MODE_MARK && skip) state_d = word_end ? ST_DONE : ST_READ;
				else state_d = ST_BIT;
			end
			ST_BIT: begin
				unique case (mode_q)
					MODE_ONE: begin
						if (!cur_bit) state_d = ST_WRITE;
						else if (nxt_end) state_d = ST_DONE;
						else if (nxt_wrap) state_d = ST_READ;
					end
					MODE_RUN: begin
						if (run_hit) state_d = ST_READ;
						else if (nxt_end) state_d = ST_DONE;
						else if (nxt_wrap) state_d = ST_READ;
					end
					default: if (nxt_end || nxt_wrap) state_d = ST_WRITE;
				endcase
			end
			ST_WRITE: state_d = fin_q ? ST_DONE : ST_READ;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath and RAM control
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		mode_d     = mode_q;
		cur_d      = cur_q;
		stop_d     = stop_q;
		len_d      = len_q;
		run_d      = run_q;
		reserve_d  = reserve_q;
		fin_d      = fin_q;
		res_ok_d   = res_ok_q;
		res_addr_d = res_addr_q;
		word_d     = word_q;
		wa_d       = wa_q;
		clr_d      = clr_q;
		fc_d       = fc_q;
		used_d     = used_q;
		mem_we     = 1'b0;
		mem_wa     = wa_q;
		mem_wd     = word_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = {WORD_BITS{1'b1}};
				clr_d  = clr_q + AW'(1);
			end
			ST_IDLE: begin
				if (accept) begin
					mode_d     = dec_mode;
					cur_d      = dec_cur;
					stop_d     = dec_stop;
					reserve_d  = dec_reserve;
					run_d      = in_data.run_frames;
					len_d      = '0;
					fin_d      = 1'b0;
					res_ok_d   = dec_ok;
					res_addr_d = '0;
				end
			end
			ST_READ: wa_d = cur_word;
			ST_LOAD: begin
				word_d = rd_data_q;
				if (mode_q != MODE_MARK && skip) begin
					cur_d = CNT_W'(word_nxt);
					if (mode_q == MODE_RUN) len_d = ld_all1 ? '0 : len_q + CNT_W'(WORD_BITS);
				end
			end
			ST_BIT: begin
				unique case (mode_q)
					MODE_ONE: begin
						if (!cur_bit) begin
							word_d[bit_idx] = 1'b1;
							if (used_q != CNT_W'(CNT_MAX)) used_d = used_q + CNT_W'(1);
							res_ok_d   = 1'b1;
							res_addr_d = frame_to_addr(cur_q);
							fin_d      = 1'b1;
						end else begin
							cur_d = CNT_W'(nxt);
						end
					end
					MODE_RUN: begin
						len_d = len_n;
						if (run_hit) begin
							// run ends here: go back and reserve it
							cur_d      = CNT_W'(nxt) - run_q;
							stop_d     = CNT_W'(nxt);
							mode_d     = MODE_MARK;
							reserve_d  = 1'b1;
							res_ok_d   = 1'b1;
							res_addr_d = frame_to_addr(CNT_W'(nxt) - run_q);
						end else begin
							cur_d = CNT_W'(nxt);
						end
					end
					default: begin
						if (reserve_q != cur_bit) begin
							word_d[bit_idx] = reserve_q;
							if (reserve_q && used_q != CNT_W'(CNT_MAX))
								used_d = used_q + CNT_W'(1);
							else if (!reserve_q && used_q != '0)
								used_d = used_q - CNT_W'(1);
						end
						cur_d = CNT_W'(nxt);
						fin_d = nxt_end;
					end
				endcase
			end
			ST_WRITE: mem_we = 1'b1;
			ST_DONE:  ;
			default:  ;
		endcase
		if (cfg_we) begin
			fc_d   = cfg_fc;
			used_d = cfg_fc;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[cur_word];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fc_q        <= RESET_FC;
			used_q      <= RESET_FC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			fc_q    <= fc_d;
			used_q  <= used_d;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		cur_q      <= cur_d;
		stop_q     <= stop_d;
		len_q      <= len_d;
		run_q      <= run_d;
		reserve_q  <= reserve_d;
		fin_q      <= fin_d;
		res_ok_q   <= res_ok_d;
		res_addr_q <= res_addr_d;
		word_q     <= word_d;
		wa_q       <= wa_d;
		if (state_q == ST_DONE && out_free) begin
			out_data_q.ok          <= res_ok_q;
			out_data_q.frame_addr  <= res_addr_q;
			out_data_q.used_frames <= used_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// cursor stays inside the active range while frames are walked
	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BIT |-> cur_q < stop_q)
		else $error("frame cursor past its limit");

	// the word being edited is the one the cursor points into
	a_word_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BIT |-> cur_word == wa_q)
		else $error("cursor left the loaded word");

	// a new result only comes out of the result state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result word without a finished command");

	// a failed command never reports an address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.frame_addr == '0)
		else $error("failed result carries an address");

	// alloc-one scan only runs while the used count is below the frame count
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BIT && mode_q == MODE_ONE |-> used_q < fc_q)
		else $error("alloc scan started on a full bitmap");

endmodule
